// ===== src/ght_pkg.sv =====
// Shared types and codes for the generational handle table.
package ght_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int GEN_W     = 32;
	localparam int TAG_W     = 32;
	localparam int SLOT_W    = 16;
	localparam int REQ_W     = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC    = 3'd0,
		REQ_BIND     = 3'd1,
		REQ_RELEASE  = 3'd2,
		REQ_RESOLVE  = 3'd3,
		REQ_VALIDATE = 3'd4
	} req_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RD    = 9'b000000010,
		ST_WAIT  = 9'b000000100,
		ST_EXEC  = 9'b000001000,
		ST_SCAN  = 9'b000010000,
		ST_SWAIT = 9'b000100000,
		ST_SMOVE = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_CLR   = 9'b100000000
	} state_t;

endpackage

// ===== src/ght_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module ght_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/generational_handle_table.sv =====
// Top level of the generational handle table.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | req_type slot_index generation_in owner_tag
//  rsp     | out       | rsp_valid/ready   | done_ok slot_out generation_out owner_out owner_matches
//
// Allocate, release, resolve and validate pass through memory read, read
// latency, compute/write, then the result register.
// A successful bind adds a pass over the free stack, one stacked entry at a
// time (scan, read wait, move), through the single read port of the stack RAM.
// After reset a clearing pass over all SLOTS entries zeroes the owner and
// generation RAMs; no item is accepted meanwhile. A stalled result holds.
module generational_handle_table #(
	parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [ght_pkg::REQ_W-1:0] req_type,
	input  logic [ght_pkg::SLOT_W-1:0] slot_index,
	input  logic [ght_pkg::GEN_W-1:0] generation_in,
	input  logic [ght_pkg::TAG_W-1:0] owner_tag,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic                      done_ok,
	output logic [ght_pkg::SLOT_W-1:0] slot_out,
	output logic [ght_pkg::GEN_W-1:0] generation_out,
	output logic [ght_pkg::TAG_W-1:0] owner_out,
	output logic                      owner_matches
);
	import ght_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	state_t state_q;
	logic [REQ_W-1:0] req_q;
	logic [SLOT_W-1:0] slot_q;
	logic [GEN_W-1:0] gen_q;
	logic [TAG_W-1:0] tag_q;
	logic [CW-1:0] free_cnt_q, fresh_q, rd_q, wr_q;
	logic [AW-1:0] tgt_q;
	logic hv_q;

	logic         own_we, gen_we, stk_we;
	logic [AW-1:0] own_wa, stk_wa, stk_ra, mem_ra;
	logic [TAG_W-1:0] own_wd, own_rd;
	logic [GEN_W-1:0] gen_wd, gen_rd;
	logic [AW-1:0] stk_wd, stk_rd;

	ght_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_own (
		.clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
		.raddr(mem_ra), .rdata(own_rd));
	ght_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen (
		.clk(clk), .we(gen_we), .waddr(own_wa), .wdata(gen_wd),
		.raddr(mem_ra), .rdata(gen_rd));
	ght_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.raddr(stk_ra), .rdata(stk_rd));

	assign req_ready = (state_q == ST_IDLE) && !rsp_valid;

	logic [GEN_W-1:0] gen_inc;
	logic [TAG_W-1:0] look;
	assign gen_inc = (gen_rd == '1) ? GEN_W'(1) : gen_rd + GEN_W'(1);
	assign look = (hv_q && gen_rd == gen_q) ? own_rd : '0;

	// allocate source: top of stack if nonempty, else fresh pointer
	assign stk_ra = (state_q == ST_RD) ? AW'(free_cnt_q - CW'(1)) : rd_q[AW-1:0];
	assign mem_ra = (state_q == ST_WAIT && req_q == REQ_ALLOC) ?
		((free_cnt_q != '0) ? stk_rd : fresh_q[AW-1:0]) : tgt_q;

	always_comb begin
		own_we = 1'b0;
		gen_we = 1'b0;
		stk_we = 1'b0;
		own_wa = tgt_q;
		own_wd = '0;
		gen_wd = '0;
		stk_wa = wr_q[AW-1:0];
		stk_wd = stk_rd;
		if (state_q == ST_CLR) begin
			own_we = 1'b1;
			gen_we = 1'b1;
			own_wa = wr_q[AW-1:0];
		end else if (state_q == ST_EXEC) begin
			case (req_q)
				REQ_ALLOC: begin
					own_we = 1'b1;
					gen_we = 1'b1;
					own_wd = tag_q;
					gen_wd = gen_inc;
				end
				REQ_BIND: begin
					own_we = hv_q && tag_q != '0;
					gen_we = own_we;
					own_wd = tag_q;
					gen_wd = gen_q;
				end
				REQ_RELEASE: begin
					own_we = hv_q && gen_rd == gen_q && own_rd != '0;
					stk_we = own_we;
					stk_wa = free_cnt_q[AW-1:0];
					stk_wd = tgt_q;
				end
				default: ;
			endcase
		end else if (state_q == ST_SMOVE) begin
			stk_we = stk_rd != tgt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			rsp_valid  <= 1'b0;
			free_cnt_q <= '0;
			fresh_q    <= '0;
			wr_q       <= '0;
			rd_q       <= '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					wr_q <= wr_q + CW'(1);
					if (wr_q == CW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						req_q   <= req_type;
						slot_q  <= slot_index;
						gen_q   <= generation_in;
						tag_q   <= owner_tag;
						tgt_q   <= slot_index[AW-1:0];
						hv_q    <= generation_in != '0 && 32'(slot_index) < 32'(SLOTS);
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_WAIT;
				ST_WAIT: begin
					done_ok <= 1'b0;
					slot_out <= '0;
					generation_out <= '0;
					owner_out <= '0;
					owner_matches <= 1'b0;
					if (req_q == REQ_ALLOC) begin
						if (tag_q == '0) begin
							state_q <= ST_OUT;
						end else if (free_cnt_q != '0) begin
							tgt_q <= stk_rd;
							free_cnt_q <= free_cnt_q - CW'(1);
							state_q <= ST_EXEC;
						end else if (fresh_q < CW'(SLOTS)) begin
							tgt_q <= fresh_q[AW-1:0];
							fresh_q <= fresh_q + CW'(1);
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_OUT;
					case (req_q)
						REQ_ALLOC: begin
							done_ok <= 1'b1;
							slot_out <= SLOT_W'(tgt_q);
							generation_out <= gen_inc;
						end
						REQ_BIND: begin
							if (hv_q && tag_q != '0) begin
								done_ok <= 1'b1;
								if (CW'(slot_q) >= fresh_q) begin
									fresh_q <= CW'(slot_q) + CW'(1);
								end
								rd_q <= '0;
								wr_q <= '0;
								state_q <= ST_SCAN;
							end
						end
						REQ_RELEASE: begin
							if (own_we) begin
								done_ok <= 1'b1;
								free_cnt_q <= free_cnt_q + CW'(1);
							end
						end
						REQ_RESOLVE: begin
							done_ok <= look != '0;
							owner_out <= look;
						end
						REQ_VALIDATE: begin
							done_ok <= look != '0;
							owner_out <= look;
							owner_matches <= look == tag_q;
						end
						default: ;
					endcase
				end
				ST_SCAN: begin
					if (rd_q >= free_cnt_q) begin
						free_cnt_q <= wr_q;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SWAIT;
					end
				end
				ST_SWAIT: state_q <= ST_SMOVE;
				ST_SMOVE: begin
					// keep every entry but the bound slot, in order
					if (stk_we) begin
						wr_q <= wr_q + CW'(1);
					end
					rd_q <= rd_q + CW'(1);
					state_q <= ST_SCAN;
				end
				ST_OUT: begin
					rsp_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= fresh_q) else $error("free count above fresh pointer");
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CW'(SLOTS)) else $error("fresh pointer past table");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("ready while busy");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule
